// File: src/pip_pkg.sv
// Shared types for the point-in-polygon crossing-number block.
package pip_pkg;

   // Edge classification handed from the front part to the back part.
   typedef struct packed {
      logic first;       // transaction starts a polygon, parity restarts
      logic last;        // transaction closes the polygon, a result is due
      logic main_span;   // edge from the prior vertex spans the query y
      logic main_up;     // that edge runs upward (y2 > y1)
      logic close_span;  // closing edge back to the first vertex spans the query y
      logic close_up;    // closing edge runs upward
   } edge_flags_type;

endpackage

// File: src/pip_if.sv
// Handshake channel interfaces for vertex requests and inside responses.
interface pip_req_if #(
   parameter int COORD_WIDTH = 16
) ();
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] vertex_x;
   logic signed [COORD_WIDTH-1:0] vertex_y;
   logic signed [COORD_WIDTH-1:0] point_x;
   logic signed [COORD_WIDTH-1:0] point_y;
   logic                          first_vertex;
   logic                          last_vertex;

   modport source (
      output valid, vertex_x, vertex_y, point_x, point_y, first_vertex, last_vertex,
      input  ready
   );
   modport sink (
      input  valid, vertex_x, vertex_y, point_x, point_y, first_vertex, last_vertex,
      output ready
   );
endinterface

interface pip_rsp_if ();
   logic valid;
   logic ready;
   logic inside_res;

   modport source (
      output valid, inside_res,
      input  ready
   );
   modport sink (
      input  valid, inside_res,
      output ready
   );
endinterface

// File: src/pip_front.sv
// Front part: holds polygon state and turns each vertex into edge operands and flags.
module pip_front #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   pip_req_if.sink                        req_ch,
   input  logic                           queue_full,
   output logic                           push,
   output pip_pkg::edge_flags_type        push_flags,
   output logic signed [COORD_WIDTH:0]    main_a,
   output logic signed [COORD_WIDTH:0]    main_b,
   output logic signed [COORD_WIDTH:0]    main_c,
   output logic signed [COORD_WIDTH:0]    main_d,
   output logic signed [COORD_WIDTH:0]    close_a,
   output logic signed [COORD_WIDTH:0]    close_b,
   output logic signed [COORD_WIDTH:0]    close_c,
   output logic signed [COORD_WIDTH:0]    close_d
);
   import pip_pkg::*;

   localparam int OpWidth = COORD_WIDTH + 1;

   logic signed [COORD_WIDTH-1:0] start_x_ff, start_y_ff, start_x_in, start_y_in;
   logic signed [COORD_WIDTH-1:0] prior_x_ff, prior_y_ff;
   logic signed [COORD_WIDTH-1:0] query_x_ff, query_y_ff, query_x_in, query_y_in;
   logic                          accept;

   assign req_ch.ready = !queue_full;
   assign accept       = req_ch.valid && req_ch.ready;
   assign push         = accept;

   // A first vertex takes effect for its own closing edge straight away.
   assign start_x_in = req_ch.first_vertex ? req_ch.vertex_x : start_x_ff;
   assign start_y_in = req_ch.first_vertex ? req_ch.vertex_y : start_y_ff;
   assign query_x_in = req_ch.first_vertex ? req_ch.point_x  : query_x_ff;
   assign query_y_in = req_ch.first_vertex ? req_ch.point_y  : query_y_ff;

   always_comb begin
      // Edge from the prior vertex to this one, against the stored point.
      main_a = OpWidth'(query_x_ff)      - OpWidth'(prior_x_ff);
      main_b = OpWidth'(req_ch.vertex_y) - OpWidth'(prior_y_ff);
      main_c = OpWidth'(req_ch.vertex_x) - OpWidth'(prior_x_ff);
      main_d = OpWidth'(query_y_ff)      - OpWidth'(prior_y_ff);
      // Closing edge from this vertex back to the first one.
      close_a = OpWidth'(query_x_in)     - OpWidth'(req_ch.vertex_x);
      close_b = OpWidth'(start_y_in)     - OpWidth'(req_ch.vertex_y);
      close_c = OpWidth'(start_x_in)     - OpWidth'(req_ch.vertex_x);
      close_d = OpWidth'(query_y_in)     - OpWidth'(req_ch.vertex_y);

      push_flags.first      = req_ch.first_vertex;
      push_flags.last       = req_ch.last_vertex;
      push_flags.main_span  = !req_ch.first_vertex &&
                              ((prior_y_ff >= query_y_ff) != (req_ch.vertex_y >= query_y_ff));
      push_flags.main_up    = req_ch.vertex_y > prior_y_ff;
      push_flags.close_span = req_ch.last_vertex &&
                              ((req_ch.vertex_y >= query_y_in) != (start_y_in >= query_y_in));
      push_flags.close_up   = start_y_in > req_ch.vertex_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_x_ff <= '0;
         start_y_ff <= '0;
         prior_x_ff <= '0;
         prior_y_ff <= '0;
         query_x_ff <= '0;
         query_y_ff <= '0;
      end else if (accept) begin
         start_x_ff <= start_x_in;
         start_y_ff <= start_y_in;
         query_x_ff <= query_x_in;
         query_y_ff <= query_y_in;
         prior_x_ff <= req_ch.vertex_x;
         prior_y_ff <= req_ch.vertex_y;
      end
   end

endmodule

// File: src/pip_queue.sv
// Short register queue that decouples the front part from the back part.
module pip_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output logic [WIDTH-1:0] pop_data
);
   localparam int PtrWidth   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CountWidth = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]      entry_ff [DEPTH];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0] count_ff, count_in;

   assign full      = count_ff == CountWidth'(DEPTH);
   assign not_empty = count_ff != '0;
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: src/pip_back.sv
// Back part: cross-multiplies both edges, updates the parity and holds the response.
module pip_back #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           entry_valid,
   output logic                           pop,
   input  pip_pkg::edge_flags_type        entry_flags,
   input  logic signed [COORD_WIDTH:0]    main_a,
   input  logic signed [COORD_WIDTH:0]    main_b,
   input  logic signed [COORD_WIDTH:0]    main_c,
   input  logic signed [COORD_WIDTH:0]    main_d,
   input  logic signed [COORD_WIDTH:0]    close_a,
   input  logic signed [COORD_WIDTH:0]    close_b,
   input  logic signed [COORD_WIDTH:0]    close_c,
   input  logic signed [COORD_WIDTH:0]    close_d,
   pip_rsp_if.source                      rsp_ch
);
   import pip_pkg::*;

   localparam int ProdWidth = 2 * (COORD_WIDTH + 1);

   logic                         advance;
   logic                         mul_valid_ff;
   edge_flags_type               mul_flags_ff;
   logic signed [ProdWidth-1:0]  main_ab_ff, main_cd_ff, close_ab_ff, close_cd_ff;
   logic                         main_left, close_left;
   logic                         parity_ff, parity_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         inside_ff;

   // The whole back pipeline moves unless a response is waiting to be taken.
   assign advance = !rsp_valid_ff || rsp_ch.ready;
   assign pop     = advance && entry_valid;

   // A point left of the crossing means the sign test flips with edge direction.
   always_comb begin
      main_left  = mul_flags_ff.main_up  ? (main_ab_ff  < main_cd_ff)
                                         : (main_ab_ff  > main_cd_ff);
      close_left = mul_flags_ff.close_up ? (close_ab_ff < close_cd_ff)
                                         : (close_ab_ff > close_cd_ff);
      parity_in  = (mul_flags_ff.first ? 1'b0 : parity_ff)
                   ^ (mul_flags_ff.main_span  && main_left)
                   ^ (mul_flags_ff.close_span && close_left);
      rsp_valid_in = mul_valid_ff && mul_flags_ff.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         parity_ff    <= 1'b0;
      end else if (advance) begin
         mul_valid_ff <= entry_valid;
         rsp_valid_ff <= rsp_valid_in;
         if (mul_valid_ff) begin
            parity_ff <= parity_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mul_flags_ff <= entry_flags;
         main_ab_ff   <= ProdWidth'(main_a)  * ProdWidth'(main_b);
         main_cd_ff   <= ProdWidth'(main_c)  * ProdWidth'(main_d);
         close_ab_ff  <= ProdWidth'(close_a) * ProdWidth'(close_b);
         close_cd_ff  <= ProdWidth'(close_c) * ProdWidth'(close_d);
         inside_ff    <= parity_in;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.inside_res = inside_ff;

endmodule

// File: src/point_in_polygon_top.sv
// A last vertex's result goes via the queue, the multiplier stage and the response register.
// Throughput: one vertex per cycle; the front part stalls only when the two-entry
// queue is full, which happens only while a response is held back by the sink.
// Each vertex needs one pass through the four-multiplier stage of the back part.
// Reset is synchronous and clears the polygon state, the parity, the queue and the pipeline.
module point_in_polygon_top #(
   parameter int COORD_WIDTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   pip_req_if.sink    req_ch,
   pip_rsp_if.source  rsp_ch
);
   import pip_pkg::*;

   localparam int OpWidth    = COORD_WIDTH + 1;
   localparam int FlagWidth  = $bits(edge_flags_type);
   localparam int QueueWidth = 8 * OpWidth + FlagWidth;

   logic                        push, queue_full, pop, entry_valid;
   edge_flags_type              push_flags, entry_flags;
   logic signed [OpWidth-1:0]   f_main_a, f_main_b, f_main_c, f_main_d;
   logic signed [OpWidth-1:0]   f_close_a, f_close_b, f_close_c, f_close_d;
   logic signed [OpWidth-1:0]   b_main_a, b_main_b, b_main_c, b_main_d;
   logic signed [OpWidth-1:0]   b_close_a, b_close_b, b_close_c, b_close_d;
   logic [QueueWidth-1:0]       push_data, pop_data;

   pip_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .queue_full (queue_full),
      .push       (push),
      .push_flags (push_flags),
      .main_a     (f_main_a),
      .main_b     (f_main_b),
      .main_c     (f_main_c),
      .main_d     (f_main_d),
      .close_a    (f_close_a),
      .close_b    (f_close_b),
      .close_c    (f_close_c),
      .close_d    (f_close_d)
   );

   assign push_data = {push_flags, f_main_a, f_main_b, f_main_c, f_main_d,
                       f_close_a, f_close_b, f_close_c, f_close_d};

   pip_queue #(.WIDTH(QueueWidth), .DEPTH(2)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .not_empty (entry_valid),
      .pop_data  (pop_data)
   );

   assign {entry_flags, b_main_a, b_main_b, b_main_c, b_main_d,
           b_close_a, b_close_b, b_close_c, b_close_d} = pop_data;

   pip_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
      .clock       (clock),
      .reset       (reset),
      .entry_valid (entry_valid),
      .pop         (pop),
      .entry_flags (entry_flags),
      .main_a      (b_main_a),
      .main_b      (b_main_b),
      .main_c      (b_main_c),
      .main_d      (b_main_d),
      .close_a     (b_close_a),
      .close_b     (b_close_b),
      .close_c     (b_close_c),
      .close_d     (b_close_d),
      .rsp_ch      (rsp_ch)
   );

   // No response can be pending straight after reset.
   assert property (@(posedge clock) reset |=> !rsp_ch.valid)
      else $error("response valid after reset");

   // A first vertex has no edge from a prior vertex.
   assert property (@(posedge clock) disable iff (reset)
      push && push_flags.first |-> !push_flags.main_span)
      else $error("edge tested on a first vertex");

   // A one-vertex polygon closes on itself, so its closing edge never spans.
   assert property (@(posedge clock) disable iff (reset)
      push && push_flags.first && push_flags.last |-> !push_flags.close_span)
      else $error("degenerate closing edge marked as spanning");

   // The queue is popped only when it holds a transaction.
   assert property (@(posedge clock) disable iff (reset) pop |-> entry_valid)
      else $error("pop from an empty queue");

endmodule
